[hw/rtl/hti_pkg.sv]
// ----------------------------------------------------------------------------
// hti_pkg
// Shared constants and types of the heightmap triangle interpolator.
// ----------------------------------------------------------------------------
package hti_pkg;

    // payload widths fixed by the interface
    localparam int COORD_W = 32;
    localparam int SCALE_W = 24;
    localparam int HGT_W   = 24;
    localparam int FRAC_W  = 16;
    localparam int ENTRY_W = 7;

    // saturation limits of a Q16.8 height
    localparam int HGT_MAX = 8388607;
    localparam int HGT_MIN = -8388608;

    // request opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_ORIGIN_X       = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Z       = 2'd1;
    localparam logic [1:0] REG_CELLS_PER_UNIT = 2'd2;

    localparam logic [SCALE_W-1:0] CELLS_PER_UNIT_RESET = 24'h010000;

    // control that travels down the pipeline with each request
    typedef struct packed {
        logic valid;
        logic query;
        logic outside;
    } pipe_ctl_t;

endpackage

[hw/rtl/hti_ram.sv]
// ----------------------------------------------------------------------------
// hti_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module hti_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/hti_axis_map.sv]
// ----------------------------------------------------------------------------
// hti_axis_map
// Three-stage world-to-grid mapping of one axis: origin subtract, split
// scale multiply, then recombine into cell index, fraction and bound flag.
// ----------------------------------------------------------------------------
module hti_axis_map #(
    parameter int GRID_POINTS = 128,
    parameter int CELL_W      = 7
) (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [hti_pkg::COORD_W-1:0] world,
    input  logic signed [hti_pkg::COORD_W-1:0] origin,
    input  logic        [hti_pkg::SCALE_W-1:0] scale,
    output logic        [CELL_W-1:0]           grid_cell,
    output logic        [hti_pkg::FRAC_W-1:0]  frac,
    output logic                               outside
);

    // offset is one bit wider than a coordinate, product spans 58 bits
    localparam int T_W    = hti_pkg::COORD_W + 1;
    localparam int LO_W   = 17;
    localparam int HI_W   = T_W - LO_W;
    localparam int PP_W   = LO_W + hti_pkg::SCALE_W;
    localparam int S_W    = 58;
    localparam int CI_W   = S_W - 1 - 32;

    logic signed [T_W-1:0]  t_next;
    logic signed [T_W-1:0]  t_reg;
    logic        [PP_W-1:0] pp_lo_next;
    logic        [PP_W-1:0] pp_lo_reg;
    logic signed [PP_W-1:0] pp_hi_next;
    logic signed [PP_W-1:0] pp_hi_reg;
    logic signed [HI_W-1:0] t_hi;
    logic signed [hti_pkg::SCALE_W:0] scale_s;
    logic signed [S_W-1:0]  s_val;
    logic        [CI_W-1:0] cell_idx;
    logic                   outside_next;
    logic        [CELL_W-1:0]          cell_reg;
    logic        [hti_pkg::FRAC_W-1:0] frac_reg;
    logic                              outside_reg;

    assign t_next = T_W'(world) - T_W'(origin);

    // offset split into an unsigned low half and a signed high half
    assign t_hi       = t_reg[T_W-1:LO_W];
    assign scale_s    = $signed({1'b0, scale});
    assign pp_lo_next = PP_W'(t_reg[LO_W-1:0]) * PP_W'(scale);
    assign pp_hi_next = PP_W'(t_hi) * PP_W'(scale_s);

    assign s_val    = (S_W'(pp_hi_reg) <<< LO_W) + S_W'($signed({1'b0, pp_lo_reg}));
    assign cell_idx = s_val[S_W-2:32];

    // negative offset or +1 corner past the last grid point
    assign outside_next = s_val[S_W-1] || (cell_idx > CI_W'(GRID_POINTS - 2));

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg       <= t_next;
            pp_lo_reg   <= pp_lo_next;
            pp_hi_reg   <= pp_hi_next;
            cell_reg    <= s_val[32+CELL_W-1:32];
            frac_reg    <= s_val[31:16];
            outside_reg <= outside_next;
        end
    end

    assign grid_cell = cell_reg;
    assign frac      = frac_reg;
    assign outside   = outside_reg;

endmodule

[hw/rtl/hti_blend.sv]
// ----------------------------------------------------------------------------
// hti_blend
// Barycentric blend of three corner heights: triangle select and edge
// deltas, two weight multiplies, then sum, round and saturate.
// ----------------------------------------------------------------------------
module hti_blend (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [hti_pkg::HGT_W-1:0]  h00,
    input  logic signed [hti_pkg::HGT_W-1:0]  h10,
    input  logic signed [hti_pkg::HGT_W-1:0]  h01,
    input  logic signed [hti_pkg::HGT_W-1:0]  h11,
    input  logic        [hti_pkg::FRAC_W-1:0] fx,
    input  logic        [hti_pkg::FRAC_W-1:0] fz,
    output logic signed [hti_pkg::HGT_W-1:0]  height
);

    localparam int D_W   = hti_pkg::HGT_W + 1;
    localparam int M_W   = hti_pkg::FRAC_W + 1 + D_W;
    localparam int ACC_W = 44;
    localparam int RES_W = ACC_W - hti_pkg::FRAC_W;

    logic                             lower;
    logic        [hti_pkg::FRAC_W:0]  fsum;
    logic signed [hti_pkg::HGT_W-1:0] base_next;
    logic signed [D_W-1:0]            d1_next;
    logic signed [D_W-1:0]            d2_next;
    logic        [hti_pkg::FRAC_W-1:0] c2_next;
    logic        [hti_pkg::FRAC_W:0]  c2_wide;

    logic signed [hti_pkg::HGT_W-1:0] base_reg;
    logic signed [D_W-1:0]            d1_reg;
    logic signed [D_W-1:0]            d2_reg;
    logic        [hti_pkg::FRAC_W-1:0] c1_reg;
    logic        [hti_pkg::FRAC_W-1:0] c2_reg;

    logic signed [M_W-1:0]            m1_next;
    logic signed [M_W-1:0]            m2_next;
    logic signed [hti_pkg::HGT_W-1:0] base2_reg;
    logic signed [M_W-1:0]            m1_reg;
    logic signed [M_W-1:0]            m2_reg;

    logic signed [ACC_W-1:0]          acc;
    logic signed [RES_W-1:0]          res;

    assign fsum  = {1'b0, fx} + {1'b0, fz};
    assign lower = !fsum[hti_pkg::FRAC_W];

    // upper triangle has fz > 0, so one minus fz fits in 16 bits
    assign c2_wide   = {1'b1, {hti_pkg::FRAC_W{1'b0}}} - {1'b0, fz};
    assign base_next = lower ? h00 : h01;
    assign d1_next   = lower ? (D_W'(h10) - D_W'(h00)) : (D_W'(h11) - D_W'(h01));
    assign d2_next   = lower ? (D_W'(h01) - D_W'(h00)) : (D_W'(h10) - D_W'(h11));
    assign c2_next   = lower ? fz : c2_wide[hti_pkg::FRAC_W-1:0];

    assign m1_next = M_W'($signed({1'b0, c1_reg})) * M_W'(d1_reg);
    assign m2_next = M_W'($signed({1'b0, c2_reg})) * M_W'(d2_reg);

    // add half an lsb, then floor
    assign acc = (ACC_W'(base2_reg) <<< hti_pkg::FRAC_W) + ACC_W'(m1_reg) + ACC_W'(m2_reg)
               + ACC_W'(32768);
    assign res = acc[ACC_W-1:hti_pkg::FRAC_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            base_reg  <= base_next;
            d1_reg    <= d1_next;
            d2_reg    <= d2_next;
            c1_reg    <= fx;
            c2_reg    <= c2_next;
            base2_reg <= base_reg;
            m1_reg    <= m1_next;
            m2_reg    <= m2_next;
        end
    end

    always_comb begin
        if (res > RES_W'(hti_pkg::HGT_MAX)) begin
            height = hti_pkg::HGT_W'(hti_pkg::HGT_MAX);
        end else if (res < RES_W'(hti_pkg::HGT_MIN)) begin
            height = hti_pkg::HGT_W'(hti_pkg::HGT_MIN);
        end else begin
            height = res[hti_pkg::HGT_W-1:0];
        end
    end

endmodule

[hw/rtl/heightmap_triangle_interpolator.sv]
// ----------------------------------------------------------------------------
// heightmap_triangle_interpolator
// Grid of Q16.8 heights with streaming barycentric height queries.
// ----------------------------------------------------------------------------
// Takes one request per clock and returns one result per request, in order;
// a low m_ready stalls the whole pipeline in place. Stages: origin subtract,
// split scale multiply, cell/fraction and bound check, height table read,
// triangle select, weight multiply, then round and saturate into the output
// register. The height table is held in four RAM banks split by row and
// column parity, so the four cell corners come out of four read ports in
// the same cycle. Writes land in the table in the same stage where queries
// read it, so a query sees every write accepted before it. Table entries
// are undefined until written; there is no clearing pass after reset. The
// user must write registers through the APB port only while no request is
// in flight; the block itself does not enforce this.
module heightmap_triangle_interpolator #(
    parameter int GRID_POINTS = 128
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_opcode,
    input  logic signed [hti_pkg::COORD_W-1:0]  s_world_x,
    input  logic signed [hti_pkg::COORD_W-1:0]  s_world_z,
    input  logic        [hti_pkg::ENTRY_W-1:0]  s_entry_col,
    input  logic        [hti_pkg::ENTRY_W-1:0]  s_entry_row,
    input  logic signed [hti_pkg::HGT_W-1:0]    s_entry_height,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [hti_pkg::HGT_W-1:0]    m_height_out,
    output logic                                m_outside_grid,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic        [3:0]                   paddr,
    input  logic        [31:0]                  pwdata,
    output logic        [31:0]                  prdata,
    output logic                                pready
);

    localparam int CELL_W     = $clog2(GRID_POINTS);
    localparam int HW         = (CELL_W > 1) ? CELL_W - 1 : 1;
    localparam int BANK_AW    = 2 * HW;
    localparam int BANK_DEPTH = 1 << BANK_AW;

    // configuration registers
    logic signed [hti_pkg::COORD_W-1:0] origin_x_reg;
    logic signed [hti_pkg::COORD_W-1:0] origin_z_reg;
    logic        [hti_pkg::SCALE_W-1:0] cells_per_unit_reg;
    logic                               cfg_wr;

    // pipeline control
    logic                 adv;
    hti_pkg::pipe_ctl_t   ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg, ctl6_reg;
    hti_pkg::pipe_ctl_t   ctl1_next, ctl4_next;

    // write request fields, carried to the table stage
    logic                              wr_ok_next;
    logic                              wr_ok1_reg, wr_ok2_reg, wr_ok3_reg;
    logic [hti_pkg::ENTRY_W-1:0]       wcol1_reg, wcol2_reg, wcol3_reg;
    logic [hti_pkg::ENTRY_W-1:0]       wrow1_reg, wrow2_reg, wrow3_reg;
    logic [hti_pkg::HGT_W-1:0]         whgt1_reg, whgt2_reg, whgt3_reg;

    // axis mapping results
    logic [CELL_W-1:0]          cell_x, cell_z;
    logic [hti_pkg::FRAC_W-1:0] frac_x, frac_z;
    logic                       out_x, out_z;

    // table stage
    logic [CELL_W-1:0]          cx1, cz1, wcol_c, wrow_c;
    logic [hti_pkg::HGT_W-1:0]  bank_rdata [4];
    logic                       cx0_reg, cz0_reg;
    logic [hti_pkg::FRAC_W-1:0] fx4_reg, fz4_reg;

    logic signed [hti_pkg::HGT_W-1:0] h00, h10, h01, h11, blend_h;

    logic                             m_valid_reg;
    logic signed [hti_pkg::HGT_W-1:0] m_height_out_reg;
    logic                             m_outside_grid_reg;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg       <= '0;
            origin_z_reg       <= '0;
            cells_per_unit_reg <= hti_pkg::CELLS_PER_UNIT_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                hti_pkg::REG_ORIGIN_X:       origin_x_reg       <= pwdata;
                hti_pkg::REG_ORIGIN_Z:       origin_z_reg       <= pwdata;
                hti_pkg::REG_CELLS_PER_UNIT: cells_per_unit_reg <= pwdata[hti_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            hti_pkg::REG_ORIGIN_X:       prdata = origin_x_reg;
            hti_pkg::REG_ORIGIN_Z:       prdata = origin_z_reg;
            hti_pkg::REG_CELLS_PER_UNIT: prdata = 32'(cells_per_unit_reg);
            default:                     prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    assign ctl1_next.valid   = s_valid;
    assign ctl1_next.query   = (s_opcode == hti_pkg::OP_QUERY);
    assign ctl1_next.outside = 1'b0;

    assign ctl4_next.valid   = ctl3_reg.valid;
    assign ctl4_next.query   = ctl3_reg.query;
    assign ctl4_next.outside = out_x || out_z;

    assign wr_ok_next = (32'(s_entry_col) < 32'(GRID_POINTS))
                     && (32'(s_entry_row) < 32'(GRID_POINTS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg    <= '0;
            ctl2_reg    <= '0;
            ctl3_reg    <= '0;
            ctl4_reg    <= '0;
            ctl5_reg    <= '0;
            ctl6_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            ctl1_reg    <= ctl1_next;
            ctl2_reg    <= ctl1_reg;
            ctl3_reg    <= ctl2_reg;
            ctl4_reg    <= ctl4_next;
            ctl5_reg    <= ctl4_reg;
            ctl6_reg    <= ctl5_reg;
            m_valid_reg <= ctl6_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            wr_ok1_reg <= wr_ok_next;
            wcol1_reg  <= s_entry_col;
            wrow1_reg  <= s_entry_row;
            whgt1_reg  <= s_entry_height;
            wr_ok2_reg <= wr_ok1_reg;
            wcol2_reg  <= wcol1_reg;
            wrow2_reg  <= wrow1_reg;
            whgt2_reg  <= whgt1_reg;
            wr_ok3_reg <= wr_ok2_reg;
            wcol3_reg  <= wcol2_reg;
            wrow3_reg  <= wrow2_reg;
            whgt3_reg  <= whgt2_reg;
        end
    end

    // ---------------- world to grid ----------------
    hti_axis_map #(
        .GRID_POINTS (GRID_POINTS),
        .CELL_W      (CELL_W)
    ) u_axis_x (
        .aclk      (aclk),
        .en        (adv),
        .world     (s_world_x),
        .origin    (origin_x_reg),
        .scale     (cells_per_unit_reg),
        .grid_cell (cell_x),
        .frac      (frac_x),
        .outside   (out_x)
    );

    hti_axis_map #(
        .GRID_POINTS (GRID_POINTS),
        .CELL_W      (CELL_W)
    ) u_axis_z (
        .aclk      (aclk),
        .en        (adv),
        .world     (s_world_z),
        .origin    (origin_z_reg),
        .scale     (cells_per_unit_reg),
        .grid_cell (cell_z),
        .frac      (frac_z),
        .outside   (out_z)
    );

    // ---------------- height table, four parity banks ----------------
    assign cx1    = CELL_W'(cell_x + 1'b1);
    assign cz1    = CELL_W'(cell_z + 1'b1);
    assign wcol_c = CELL_W'(wcol3_reg);
    assign wrow_c = CELL_W'(wrow3_reg);

    for (genvar gb = 0; gb < 4; gb++) begin : g_bank
        localparam logic PX = 1'((gb >> 1) & 1);
        localparam logic PZ = 1'(gb & 1);

        logic [CELL_W-1:0]  rcol, rrow;
        logic [BANK_AW-1:0] raddr, waddr;
        logic               we;

        // bank holds the corner whose column and row parity match its own
        assign rcol  = (cell_x[0] == PX) ? cell_x : cx1;
        assign rrow  = (cell_z[0] == PZ) ? cell_z : cz1;
        assign raddr = {HW'(rcol >> 1), HW'(rrow >> 1)};
        assign waddr = {HW'(wcol_c >> 1), HW'(wrow_c >> 1)};
        assign we    = adv && ctl3_reg.valid && !ctl3_reg.query && wr_ok3_reg
                    && (wcol_c[0] == PX) && (wrow_c[0] == PZ);

        hti_ram #(
            .WIDTH (hti_pkg::HGT_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .aclk  (aclk),
            .we    (we),
            .waddr (waddr),
            .wdata (whgt3_reg),
            .re    (adv),
            .raddr (raddr),
            .rdata (bank_rdata[gb])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cx0_reg <= cell_x[0];
            cz0_reg <= cell_z[0];
            fx4_reg <= frac_x;
            fz4_reg <= frac_z;
        end
    end

    // map banks back to corners
    assign h00 = bank_rdata[{cx0_reg,  cz0_reg}];
    assign h10 = bank_rdata[{!cx0_reg, cz0_reg}];
    assign h01 = bank_rdata[{cx0_reg,  !cz0_reg}];
    assign h11 = bank_rdata[{!cx0_reg, !cz0_reg}];

    // ---------------- blend ----------------
    hti_blend u_blend (
        .aclk   (aclk),
        .en     (adv),
        .h00    (h00),
        .h10    (h10),
        .h01    (h01),
        .h11    (h11),
        .fx     (fx4_reg),
        .fz     (fz4_reg),
        .height (blend_h)
    );

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_height_out_reg   <= (ctl6_reg.query && !ctl6_reg.outside) ? blend_h : '0;
            m_outside_grid_reg <= ctl6_reg.query && ctl6_reg.outside;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_height_out   = m_height_out_reg;
    assign m_outside_grid = m_outside_grid_reg;

endmodule

[sim/heightmap_triangle_interpolator_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heightmap_triangle_interpolator_test
// Self-checking bench for the heightmap triangle interpolator.
// ----------------------------------------------------------------------------
// Loads patches of heights, then streams queries aimed at loaded cells
// together with outside points and stray writes, under several origin and
// scale settings. A scoreboard predicts every result from its own copy of the
// grid and registers, and both handshakes idle at random.
module heightmap_triangle_interpolator_test;

    localparam int GRID  = 128;
    localparam int LIMIT = 400;

    typedef struct packed {
        logic signed [hti_pkg::HGT_W-1:0] height;
        logic                             outside;
    } height_result_t;

    class height_board;
        logic signed [hti_pkg::HGT_W-1:0]   heights [GRID*GRID];
        bit                                 written [GRID*GRID];
        bit                                 ready_mark [GRID*GRID];
        int unsigned                        ready_cells [$];  // cells with all four corners loaded
        logic signed [hti_pkg::COORD_W-1:0] org_x;
        logic signed [hti_pkg::COORD_W-1:0] org_z;
        logic        [hti_pkg::SCALE_W-1:0] scale;
        height_result_t                     awaited [$];
        int                                 mismatches;

        function new();
            org_x = '0;
            org_z = '0;
            scale = hti_pkg::CELLS_PER_UNIT_RESET;
            mismatches = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                hti_pkg::REG_ORIGIN_X: org_x = val;
                hti_pkg::REG_ORIGIN_Z: org_z = val;
                hti_pkg::REG_CELLS_PER_UNIT: scale = val[hti_pkg::SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // world coordinate to cell index and Q0.16 fraction, 0 when off the grid
        function bit map_axis(logic signed [hti_pkg::COORD_W-1:0] w,
                              logic signed [hti_pkg::COORD_W-1:0] org,
                              output longint cell_id, output longint frac);
            longint offs, scaled;
            offs = longint'(w) - longint'(org);
            scaled = offs * longint'(scale);
            cell_id = 0;
            frac = 0;
            if (scaled < 0) return 0;
            if ((scaled >>> 32) > GRID - 2) return 0;
            cell_id = scaled >>> 32;
            frac = longint'(scaled[31:16]);
            return 1;
        endfunction

        function bit loaded(int c, int r);
            return written[c*GRID+r] && written[(c+1)*GRID+r] &&
                   written[c*GRID+r+1] && written[(c+1)*GRID+r+1];
        endfunction

        function void note_request(logic op, logic signed [hti_pkg::COORD_W-1:0] wx,
                                   logic signed [hti_pkg::COORD_W-1:0] wz,
                                   logic [hti_pkg::ENTRY_W-1:0] col,
                                   logic [hti_pkg::ENTRY_W-1:0] row,
                                   logic signed [hti_pkg::HGT_W-1:0] h);
            height_result_t want;
            longint cx, cz, fx, fz, h00, h10, h01, h11, acc, res;
            int c, r;
            want = '0;
            if (op == hti_pkg::OP_WRITE) begin
                heights[int'(col)*GRID+int'(row)] = h;
                written[int'(col)*GRID+int'(row)] = 1'b1;
                for (c = int'(col) - 1; c <= int'(col); c++) begin
                    for (r = int'(row) - 1; r <= int'(row); r++) begin
                        if (c >= 0 && r >= 0 && c <= GRID-2 && r <= GRID-2 &&
                            !ready_mark[c*GRID+r] && loaded(c, r)) begin
                            ready_mark[c*GRID+r] = 1'b1;
                            ready_cells.push_back(c*GRID+r);
                        end
                    end
                end
            end else if (!map_axis(wx, org_x, cx, fx) || !map_axis(wz, org_z, cz, fz)) begin
                want.outside = 1'b1;
            end else begin
                h00 = heights[cx*GRID+cz];
                h10 = heights[(cx+1)*GRID+cz];
                h01 = heights[cx*GRID+cz+1];
                h11 = heights[(cx+1)*GRID+cz+1];
                if (fx + fz < 65536)
                    acc = h00*65536 + fx*(h10-h00) + fz*(h01-h00);
                else
                    acc = h01*65536 + fx*(h11-h01) + (65536-fz)*(h10-h11);
                res = (acc + 32768) >>> 16;
                if (res > hti_pkg::HGT_MAX) res = hti_pkg::HGT_MAX;
                if (res < hti_pkg::HGT_MIN) res = hti_pkg::HGT_MIN;
                want.height = res[hti_pkg::HGT_W-1:0];
            end
            awaited.push_back(want);
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        task check_result(logic signed [hti_pkg::HGT_W-1:0] h, logic outside);
            height_result_t want;
            if (awaited.size() == 0) begin
                report($sformatf("result h=%0d outside=%0b with no request pending", h, outside));
            end else begin
                want = awaited.pop_front();
                if (h !== want.height)
                    report($sformatf("height_out %0d, predicted %0d", h, want.height));
                if (outside !== want.outside)
                    report($sformatf("outside_grid %0b, predicted %0b", outside, want.outside));
            end
        endtask
    endclass

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic                                s_opcode = hti_pkg::OP_WRITE;
    logic signed [hti_pkg::COORD_W-1:0]  s_world_x = '0;
    logic signed [hti_pkg::COORD_W-1:0]  s_world_z = '0;
    logic        [hti_pkg::ENTRY_W-1:0]  s_entry_col = '0;
    logic        [hti_pkg::ENTRY_W-1:0]  s_entry_row = '0;
    logic signed [hti_pkg::HGT_W-1:0]    s_entry_height = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic signed [hti_pkg::HGT_W-1:0]    m_height_out;
    logic                                m_outside_grid;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic        [3:0]                   paddr = '0;
    logic        [31:0]                  pwdata = '0;
    logic        [31:0]                  prdata;
    logic                                pready;

    height_board sb = new();
    bit send_calm = 1'b0;
    bit take_calm = 1'b0;
    int idle_cycles = 0;

    heightmap_triangle_interpolator #(.GRID_POINTS(GRID)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_world_x(s_world_x), .s_world_z(s_world_z),
        .s_entry_col(s_entry_col), .s_entry_row(s_entry_row),
        .s_entry_height(s_entry_height),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_height_out(m_height_out), .m_outside_grid(m_outside_grid),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 19) == 0) calm = !calm;
        return calm ? 0 : int'($urandom_range(0, 14));
    endfunction

    function automatic logic signed [hti_pkg::HGT_W-1:0] draw_height();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? hti_pkg::HGT_W'(hti_pkg::HGT_MAX)
                                        : hti_pkg::HGT_W'(hti_pkg::HGT_MIN);
        return hti_pkg::HGT_W'($urandom);
    endfunction

    // world point whose scaled offset lands in the given cell, barring overflow
    function automatic logic signed [hti_pkg::COORD_W-1:0] aim(
            logic signed [hti_pkg::COORD_W-1:0] org, int unsigned cell_id);
        longint target, span;
        target = (longint'(cell_id) << 32) +
                 (($urandom_range(0, 7) == 0) ? 64'sd0 : longint'($urandom));
        span = longint'(sb.scale);
        return org + hti_pkg::COORD_W'((target + span - 1) / span);
    endfunction

    task automatic send(logic op, logic signed [hti_pkg::COORD_W-1:0] wx,
                        logic signed [hti_pkg::COORD_W-1:0] wz,
                        logic [hti_pkg::ENTRY_W-1:0] col, logic [hti_pkg::ENTRY_W-1:0] row,
                        logic signed [hti_pkg::HGT_W-1:0] h);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_world_x <= wx;
        s_world_z <= wz;
        s_entry_col <= col;
        s_entry_row <= row;
        s_entry_height <= h;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(op, wx, wz, col, row, h);
    endtask

    task automatic send_write(logic [hti_pkg::ENTRY_W-1:0] col, logic [hti_pkg::ENTRY_W-1:0] row,
                              logic signed [hti_pkg::HGT_W-1:0] h);
        send(hti_pkg::OP_WRITE, $urandom, $urandom, col, row, h);
    endtask

    task automatic send_query(logic signed [hti_pkg::COORD_W-1:0] wx,
                              logic signed [hti_pkg::COORD_W-1:0] wz);
        send(hti_pkg::OP_QUERY, wx, wz, hti_pkg::ENTRY_W'($urandom),
             hti_pkg::ENTRY_W'($urandom), hti_pkg::HGT_W'($urandom));
    endtask

    task automatic configure(logic signed [hti_pkg::COORD_W-1:0] ox,
                             logic signed [hti_pkg::COORD_W-1:0] oz,
                             logic [hti_pkg::SCALE_W-1:0] cpu);
        logic [1:0]  regs [3];
        logic [31:0] vals [3];
        int i;
        regs = '{hti_pkg::REG_ORIGIN_X, hti_pkg::REG_ORIGIN_Z, hti_pkg::REG_CELLS_PER_UNIT};
        vals = '{ox, oz, {8'h00, cpu}};
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        for (i = 0; i < 3; i++) begin
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= {regs[i], 2'b00};
            pwdata <= vals[i];
            @(posedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
            sb.set_reg(regs[i], vals[i]);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // 3x3 block of points, giving four fully loaded cells
    task automatic load_patch();
        int bx, bz, i;
        bx = $urandom_range(0, GRID-3);
        bz = $urandom_range(0, GRID-3);
        for (i = 0; i < 9; i++)
            send_write(hti_pkg::ENTRY_W'(bx + i/3), hti_pkg::ENTRY_W'(bz + i%3), draw_height());
    endtask

    task automatic random_item();
        int unsigned pick, tries, cell_id;
        int col, row;
        logic signed [hti_pkg::COORD_W-1:0] wx, wz;
        longint cx, cz, fx, fz;
        bit safe;
        pick = $urandom_range(0, 99);
        safe = 1'b0;
        if (pick >= 30 && sb.ready_cells.size() != 0) begin
            for (tries = 0; tries < 8 && !safe; tries++) begin
                if (pick < 85) begin
                    cell_id = sb.ready_cells[$urandom_range(0, sb.ready_cells.size()-1)];
                    wx = aim(sb.org_x, cell_id / GRID);
                    wz = aim(sb.org_z, cell_id % GRID);
                end else if ($urandom_range(0, 1)) begin
                    wx = $urandom;
                    wz = $urandom;
                end else begin
                    wx = sb.org_x + hti_pkg::COORD_W'($urandom_range(0, 32'h01FF_FFFF))
                       - 32'h0100_0000;
                    wz = sb.org_z + hti_pkg::COORD_W'($urandom_range(0, 32'h01FF_FFFF))
                       - 32'h0100_0000;
                end
                // never read a grid point that has not been loaded
                safe = !sb.map_axis(wx, sb.org_x, cx, fx) || !sb.map_axis(wz, sb.org_z, cz, fz) ||
                       sb.ready_mark[cx*GRID+cz];
            end
        end
        if (safe) begin
            send_query(wx, wz);
        end else begin
            if ($urandom_range(0, 1) && sb.ready_cells.size() != 0) begin
                cell_id = sb.ready_cells[$urandom_range(0, sb.ready_cells.size()-1)];
                col = int'(cell_id / GRID) + int'($urandom_range(0, 3)) - 1;
                row = int'(cell_id % GRID) + int'($urandom_range(0, 3)) - 1;
                col = (col < 0) ? 0 : (col > GRID-1) ? GRID-1 : col;
                row = (row < 0) ? 0 : (row > GRID-1) ? GRID-1 : row;
            end else begin
                col = $urandom_range(0, GRID-1);
                row = $urandom_range(0, GRID-1);
            end
            send_write(hti_pkg::ENTRY_W'(col), hti_pkg::ENTRY_W'(row), draw_height());
        end
    endtask

    // result side with random stalls
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_wait(take_calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_height_out, m_outside_grid);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= LIMIT) begin
            $display("heightmap_triangle_interpolator_test: done, errors");
            $finish;
        end
    end

    initial begin
        int ph, n;
        logic signed [hti_pkg::COORD_W-1:0] ox, oz;
        logic [hti_pkg::SCALE_W-1:0] cpu;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: one cell per world unit, origin at zero
        send_write(7'd0, 7'd0, 24'sd0);
        send_write(7'd1, 7'd0, 24'sd1);
        send_write(7'd0, 7'd1, -24'sd1);
        send_write(7'd1, 7'd1, hti_pkg::HGT_W'(hti_pkg::HGT_MAX));
        send_write(7'd126, 7'd126, hti_pkg::HGT_W'(hti_pkg::HGT_MIN));
        send_write(7'd127, 7'd126, hti_pkg::HGT_W'(hti_pkg::HGT_MAX));
        send_write(7'd126, 7'd127, hti_pkg::HGT_W'(hti_pkg::HGT_MAX));
        send_write(7'd127, 7'd127, hti_pkg::HGT_W'(hti_pkg::HGT_MIN));
        send_query(32'h0000_0000, 32'h0000_0000);
        send_query(32'h0000_8000, 32'h0000_0000);  // half tie rounds up
        send_query(32'h0000_0000, 32'h0000_8000);  // negative half tie
        send_query(32'h0000_8000, 32'h0000_8000);  // diagonal picks the upper triangle
        send_query(32'h0000_FFFF, 32'h0000_FFFF);
        send_query(32'h007E_FFFF, 32'h007E_0000);  // last cell on both axes
        send_query(32'h007E_4000, 32'h007E_C000);
        send_query(32'h007F_0000, 32'h0000_0000);  // +1 corner would leave the grid
        send_query(32'hFFFF_FFFF, 32'h0000_0000);  // just below origin
        send_query(32'h8000_0000, 32'h7FFF_FFFF);
        send_query(32'h0000_0000, 32'h007F_0000);

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin ox = 32'h0; oz = 32'h0; cpu = 24'h010000; end
                1: begin ox = 32'h8000_0000; oz = 32'h7FFF_FFFF; cpu = 24'h000001; end
                2: begin ox = 32'h7FFF_FFFF; oz = 32'h8000_0000; cpu = 24'hFFFFFF; end
                3: begin
                    ox = hti_pkg::COORD_W'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
                    oz = hti_pkg::COORD_W'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
                    cpu = hti_pkg::SCALE_W'($urandom_range(24'h001000, 24'h100000));
                end
                4: begin
                    ox = $urandom;
                    oz = $urandom;
                    cpu = hti_pkg::SCALE_W'($urandom_range(1, 24'hFFFFFF));
                end
                default: begin
                    ox = hti_pkg::COORD_W'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
                    oz = hti_pkg::COORD_W'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
                    cpu = hti_pkg::SCALE_W'($urandom_range(24'h010000, 24'h040000));
                end
            endcase
            configure(ox, oz, cpu);
            load_patch();
            for (n = 0; n < 85; n++)
                random_item();
        end

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("heightmap_triangle_interpolator_test: done, clean");
        else
            $display("heightmap_triangle_interpolator_test: done, errors");
        $finish;
    end

endmodule

[heightmap_triangle_interpolator.f]
hw/rtl/hti_pkg.sv
hw/rtl/hti_ram.sv
hw/rtl/hti_axis_map.sv
hw/rtl/hti_blend.sv
hw/rtl/heightmap_triangle_interpolator.sv
sim/heightmap_triangle_interpolator_test.sv
